// ===== rtl/eia_pkg.sv =====
// ----------------------------------------------------------------------------
// eia_pkg
// Shared widths, request and status codes, and controller command type for
// the entity identifier allocator.
// ----------------------------------------------------------------------------
package eia_pkg;

    localparam int ENTITY_COUNT = 256;
    localparam int ID_W         = $clog2(ENTITY_COUNT);
    localparam int CNT_W        = $clog2(ENTITY_COUNT + 1);
    localparam int FAM_W        = 16;
    localparam int REQ_W        = 3;
    localparam int STAT_W       = 2;

    localparam logic [REQ_W-1:0] REQ_CREATE  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_DESTROY = 3'd1;
    localparam logic [REQ_W-1:0] REQ_SET_FAM = 3'd2;
    localparam logic [REQ_W-1:0] REQ_GET_FAM = 3'd3;
    localparam logic [REQ_W-1:0] REQ_EXISTS  = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NO_FREE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_UNKNOWN = 2'd2;

    typedef struct packed {
        logic capture;
        logic commit;
    } t_dp_cmd;

endpackage

// ===== rtl/entity_id_allocator_with_tags.sv =====
// ----------------------------------------------------------------------------
// entity_id_allocator_with_tags
// Hands out entity identifiers with family tags; most recently freed first,
// then never-used ones.
// ----------------------------------------------------------------------------
// Each request gives one result. A request is first captured, reading the tag
// memory and the top of the free stack, then committed, updating state and
// loading the result register once that register is free or being drained.
// A new request is taken as soon as the previous one is committed, even
// while its result waits for transfer.
module entity_id_allocator_with_tags (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [eia_pkg::REQ_W-1:0]   i_req_type,
    input  logic [eia_pkg::ID_W-1:0]    i_entity_id,
    input  logic [eia_pkg::FAM_W-1:0]   i_family_id,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [eia_pkg::ID_W-1:0]    o_result_entity,
    output logic [eia_pkg::FAM_W-1:0]   o_result_family,
    output logic                        o_entity_present,
    output logic [eia_pkg::STAT_W-1:0]  o_status
);

    eia_pkg::t_dp_cmd cmd;

    eia_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (cmd)
    );

    eia_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_req_type       (i_req_type),
        .i_entity_id      (i_entity_id),
        .i_family_id      (i_family_id),
        .o_result_entity  (o_result_entity),
        .o_result_family  (o_result_family),
        .o_entity_present (o_entity_present),
        .o_status         (o_status)
    );

endmodule

// ===== rtl/eia_ctrl.sv =====
// ----------------------------------------------------------------------------
// eia_ctrl
// Sequencer: captures a request, then commits it into the output register
// once that register is free or being drained.
// ----------------------------------------------------------------------------
module eia_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    output logic            o_valid,
    input  logic            i_ready,
    output eia_pkg::t_dp_cmd o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        o_cmd.capture = (r_state == S_IDLE) && i_valid;
        o_cmd.commit  = (r_state == S_EXEC) && (!r_out_valid || i_ready);
        n_state       = r_state;
        n_out_valid   = r_out_valid;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (o_cmd.commit) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;

endmodule

// ===== rtl/eia_dpath.sv =====
// ----------------------------------------------------------------------------
// eia_dpath
// Valid marks, tag memory, free stack, counters and result register.
// ----------------------------------------------------------------------------
module eia_dpath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  eia_pkg::t_dp_cmd            i_cmd,
    input  logic [eia_pkg::REQ_W-1:0]   i_req_type,
    input  logic [eia_pkg::ID_W-1:0]    i_entity_id,
    input  logic [eia_pkg::FAM_W-1:0]   i_family_id,
    output logic [eia_pkg::ID_W-1:0]    o_result_entity,
    output logic [eia_pkg::FAM_W-1:0]   o_result_family,
    output logic                        o_entity_present,
    output logic [eia_pkg::STAT_W-1:0]  o_status
);

    logic [eia_pkg::FAM_W-1:0] fam_mem [eia_pkg::ENTITY_COUNT];
    logic [eia_pkg::ID_W-1:0]  stk_mem [eia_pkg::ENTITY_COUNT];
    logic                      r_marks [eia_pkg::ENTITY_COUNT];

    logic [eia_pkg::CNT_W-1:0]  r_free_count, n_free_count;
    logic [eia_pkg::CNT_W-1:0]  r_fresh, n_fresh;
    logic [eia_pkg::REQ_W-1:0]  r_req;
    logic [eia_pkg::ID_W-1:0]   r_eid;
    logic [eia_pkg::FAM_W-1:0]  r_fam;
    logic [eia_pkg::FAM_W-1:0]  r_fam_rd;
    logic [eia_pkg::ID_W-1:0]   r_stk_rd;
    logic                       r_known;
    logic [eia_pkg::ID_W-1:0]   r_res_ent, n_res_ent;
    logic [eia_pkg::FAM_W-1:0]  r_res_fam, n_res_fam;
    logic                       r_res_pres, n_res_pres;
    logic [eia_pkg::STAT_W-1:0] r_res_stat, n_res_stat;

    logic                       known;
    logic                       mark_we, mark_val;
    logic [eia_pkg::ID_W-1:0]   mark_addr;
    logic                       fam_we;
    logic [eia_pkg::ID_W-1:0]   fam_addr;
    logic                       stk_we;
    logic [eia_pkg::CNT_W-1:0]  stk_top;

    assign known   = r_known;
    assign stk_top = r_free_count - eia_pkg::CNT_W'(1);

    always_comb begin
        n_free_count = r_free_count;
        n_fresh      = r_fresh;
        n_res_ent    = r_eid;
        n_res_fam    = '0;
        n_res_pres   = 1'b0;
        n_res_stat   = eia_pkg::STAT_OK;
        mark_we      = 1'b0;
        mark_val     = 1'b0;
        mark_addr    = r_eid;
        fam_we       = 1'b0;
        fam_addr     = r_eid;
        stk_we       = 1'b0;
        unique case (r_req)
            eia_pkg::REQ_CREATE: begin
                if (r_free_count != '0) begin
                    n_free_count = stk_top;
                    mark_addr    = r_stk_rd;
                end else if (r_fresh != eia_pkg::CNT_W'(eia_pkg::ENTITY_COUNT)) begin
                    n_fresh   = r_fresh + eia_pkg::CNT_W'(1);
                    mark_addr = r_fresh[eia_pkg::ID_W-1:0];
                end else begin
                    n_res_stat = eia_pkg::STAT_NO_FREE;
                end
                if (n_res_stat == eia_pkg::STAT_OK) begin
                    mark_we    = 1'b1;
                    mark_val   = 1'b1;
                    fam_we     = 1'b1;
                    fam_addr   = mark_addr;
                    n_res_ent  = mark_addr;
                    n_res_fam  = r_fam;
                    n_res_pres = 1'b1;
                end else begin
                    n_res_ent = '0;
                end
            end
            eia_pkg::REQ_DESTROY: begin
                if (known) begin
                    mark_we = 1'b1;
                    if (r_free_count != eia_pkg::CNT_W'(eia_pkg::ENTITY_COUNT)) begin
                        stk_we       = 1'b1;
                        n_free_count = r_free_count + eia_pkg::CNT_W'(1);
                    end
                end else begin
                    n_res_stat = eia_pkg::STAT_UNKNOWN;
                end
            end
            eia_pkg::REQ_SET_FAM: begin
                if (known) begin
                    fam_we     = 1'b1;
                    n_res_fam  = r_fam;
                    n_res_pres = 1'b1;
                end else begin
                    n_res_stat = eia_pkg::STAT_UNKNOWN;
                end
            end
            eia_pkg::REQ_GET_FAM: begin
                if (known) begin
                    n_res_fam  = r_fam_rd;
                    n_res_pres = 1'b1;
                end else begin
                    n_res_stat = eia_pkg::STAT_UNKNOWN;
                end
            end
            default: begin
                n_res_pres = known;
            end
        endcase
    end

    // request capture and memory reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req    <= i_req_type;
            r_eid    <= i_entity_id;
            r_fam    <= i_family_id;
            r_fam_rd <= fam_mem[i_entity_id];
            r_stk_rd <= stk_mem[stk_top[eia_pkg::ID_W-1:0]];
            r_known  <= r_marks[i_entity_id];
        end
    end

    // memory writes
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && fam_we) begin
            fam_mem[fam_addr] <= r_fam;
        end
        if (i_cmd.commit && stk_we) begin
            stk_mem[r_free_count[eia_pkg::ID_W-1:0]] <= r_eid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < eia_pkg::ENTITY_COUNT; k++) begin
                r_marks[k] <= 1'b0;
            end
            r_free_count <= '0;
            r_fresh      <= '0;
        end else if (i_cmd.commit) begin
            if (mark_we) begin
                r_marks[mark_addr] <= mark_val;
            end
            r_free_count <= n_free_count;
            r_fresh      <= n_fresh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_res_ent  <= n_res_ent;
            r_res_fam  <= n_res_fam;
            r_res_pres <= n_res_pres;
            r_res_stat <= n_res_stat;
        end
    end

    assign o_result_entity  = r_res_ent;
    assign o_result_family  = r_res_fam;
    assign o_entity_present = r_res_pres;
    assign o_status         = r_res_stat;

endmodule
